// ===== rtl/grid_mesh_edge_cell_indexer_top_macros.svh =====
// Assertion macros for the mesh edge/cell indexer.
`ifndef GRID_MESH_EDGE_CELL_INDEXER_TOP_MACROS_SVH
`define GRID_MESH_EDGE_CELL_INDEXER_TOP_MACROS_SVH

// same-cycle implication
`define GMEI_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define GMEI_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/gmei_pkg.sv =====
// Shared types and codes for the mesh edge/cell indexer.
package gmei_pkg;

  localparam int DIM_BITS_DEF = 10;
  localparam int CFG_W        = 11;
  localparam int CELL_W       = 20;
  localparam int EDGE_W       = 22;
  localparam int BPS          = 4;   // quotient bits per divider stage

  localparam logic [1:0] SIDE_BOTTOM = 2'd0;
  localparam logic [1:0] SIDE_TOP    = 2'd1;
  localparam logic [1:0] SIDE_LEFT   = 2'd2;
  localparam logic [1:0] SIDE_RIGHT  = 2'd3;

  typedef enum logic [0:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    POS_BOTTOM = 3'd0,
    POS_TOP    = 3'd1,
    POS_LEFT   = 3'd2,
    POS_RIGHT  = 3'd3,
    POS_NONE   = 3'd4
  } pos_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [1:0]        cell_side;
    logic [EDGE_W-1:0] edge_index;
    logic              edge_side;
  } in_t;

  typedef struct packed {
    logic [EDGE_W-1:0] side_edge;
    logic [CELL_W-1:0] neighbor_cell;
    logic              neighbor_missing;
    logic [2:0]        edge_position;
    logic              edge_horizontal;
    logic              edge_inner;
    logic              fixed_value_boundary;
    logic              flux_boundary;
    logic              index_out_of_range;
  } out_t;

endpackage

// ===== rtl/grid_mesh_edge_cell_indexer_top.sv =====
// Top level of the structured quad mesh edge/cell indexer.
//
// Input channel (in_valid/in_stall/in_data) takes one query per cycle while
// in_stall is low: a cell with a side and an edge with a side. Output channel
// (out_valid/out_stall/out_data) returns one result per query, in order.
// Config port (cfg_we/cfg_addr/cfg_wdata) sets mesh rows and columns;
// values are saturated to 1..2^DIM_BITS. Write it only while idle.
//
// Pipeline: input reg, prep, NDS divider stages (4 quotient bits each,
// 6 at default widths), multiply, output reg. Throughput is one item per
// cycle, held only by the handshake and by the settle period below.
// Reset clears all valids. After reset and after any config write,
// in_stall stays high while the mesh size products settle.
// A stall on the output holds the output register; bubbles upstream
// still collapse, so the input keeps taking items until the pipe fills.
`include "grid_mesh_edge_cell_indexer_top_macros.svh"

module grid_mesh_edge_cell_indexer_top #(
  parameter int DIM_BITS = gmei_pkg::DIM_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gmei_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gmei_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  gmei_pkg::cfg_idx_t            cfg_addr,
  input  logic [gmei_pkg::CFG_W-1:0]    cfg_wdata
);
  import gmei_pkg::*;

  localparam int DW     = (DIM_BITS + 1 < CFG_W) ? DIM_BITS + 1 : CFG_W;
  localparam int DVW    = DW + 1;
  localparam int CW     = 2 * DW + 1;
  localparam int PW     = 2 * DVW;
  localparam int NDS    = (EDGE_W + BPS - 1) / BPS;
  localparam int DIVW   = NDS * BPS;
  localparam int NST    = NDS + 4;
  localparam int ST_MUL = NDS + 2;
  localparam int ST_OUT = NDS + 3;
  localparam logic [31:0] MAXD   = 32'd1 << DIM_BITS;
  localparam logic [1:0]  SETTLE = 2'd3;

  typedef struct packed {
    logic [1:0]      side;
    logic            es;
    logic            cell_ok;
    logic            edge_ok;
    logic            is_h;
    logic [DIVW-1:0] csr;
    logic [DVW-1:0]  crem;
    logic [DIVW-1:0] esr;
    logic [DVW-1:0]  erem;
    logic [DVW-1:0]  ediv;
  } div_t;

  typedef struct packed {
    logic           cell_ok;
    logic           edge_ok;
    logic           have_n;
    logic [PW-1:0]  pa;
    logic [DVW-1:0] ca;
    logic [CW-1:0]  hadd;
    logic [PW-1:0]  pb;
    logic [DW-1:0]  nc;
    pos_t           pos;
    logic           horiz;
    logic           inner;
    logic           fixed;
    logic           flux;
  } mul_t;

  // config and derived mesh sizes
  logic [DW-1:0]  rows_r, cols_r, cfg_dim;
  logic [DVW-1:0] colsp1_r;
  logic [CW-1:0]  ncells_r, hcount_r, nedges_r;
  logic [1:0]     settle_r;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_dim = DW'(1);
    end else if ({{(32-CFG_W){1'b0}}, cfg_wdata} > MAXD) begin
      cfg_dim = MAXD[DW-1:0];
    end else begin
      cfg_dim = cfg_wdata[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= DW'(1);
      cols_r   <= DW'(1);
      settle_r <= SETTLE;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROWS: rows_r <= cfg_dim;
        REG_COLS: cols_r <= cfg_dim;
        default: ;
      endcase
      settle_r <= SETTLE;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    ncells_r <= CW'(rows_r) * CW'(cols_r);
    colsp1_r <= {1'b0, cols_r} + DVW'(1);
    hcount_r <= ncells_r + CW'(cols_r);
    nedges_r <= (ncells_r << 1) + CW'(cols_r) + CW'(rows_r);
  end

  // handshake chain
  logic [NST-1:0] vld_r;
  logic [NST-1:0] rdy;
  logic           in_acc;

  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0] || (settle_r != 2'd0);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_acc;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // datapath
  in_t  in_r;
  div_t div_r [0:NDS];
  div_t prep_nxt;
  div_t step_nxt [1:NDS];
  mul_t mul_r, mul_nxt;
  out_t out_r, out_nxt;

  always_comb begin
    logic [EDGE_W-1:0] ev;
    logic              h;
    h  = {{(32-EDGE_W){1'b0}}, in_r.edge_index} < 32'(hcount_r);
    ev = EDGE_W'({{(32-EDGE_W){1'b0}}, in_r.edge_index} - 32'(hcount_r));
    prep_nxt.side    = in_r.cell_side;
    prep_nxt.es      = in_r.edge_side;
    prep_nxt.cell_ok = {{(32-CELL_W){1'b0}}, in_r.cell_index} < 32'(ncells_r);
    prep_nxt.edge_ok = {{(32-EDGE_W){1'b0}}, in_r.edge_index} < 32'(nedges_r);
    prep_nxt.is_h    = h;
    prep_nxt.csr     = DIVW'(in_r.cell_index);
    prep_nxt.crem    = '0;
    prep_nxt.esr     = DIVW'(h ? in_r.edge_index : ev);
    prep_nxt.erem    = '0;
    prep_nxt.ediv    = h ? {1'b0, cols_r} : colsp1_r;
  end

  // restoring division, BPS quotient bits per stage, both dividers in step
  for (genvar g = 1; g <= NDS; g++) begin : g_div
    always_comb begin
      div_t           s;
      logic [DVW:0]   t;
      logic [DVW-1:0] cd;
      s  = div_r[g-1];
      cd = {1'b0, cols_r};
      for (int i = 0; i < BPS; i++) begin
        t     = {s.crem, s.csr[DIVW-1]};
        s.csr = {s.csr[DIVW-2:0], 1'b0};
        if (t >= {1'b0, cd}) begin
          s.crem   = DVW'(t - {1'b0, cd});
          s.csr[0] = 1'b1;
        end else begin
          s.crem = t[DVW-1:0];
        end
        t     = {s.erem, s.esr[DIVW-1]};
        s.esr = {s.esr[DIVW-2:0], 1'b0};
        if (t >= {1'b0, s.ediv}) begin
          s.erem   = DVW'(t - {1'b0, s.ediv});
          s.esr[0] = 1'b1;
        end else begin
          s.erem = t[DVW-1:0];
        end
      end
      step_nxt[g] = s;
    end
  end

  always_comb begin
    div_t           d;
    logic [DW-1:0]  r, c, er, ec, ra, nr, nc;
    logic [DVW-1:0] ma, r1, c1;
    logic           side_lo, border, both;
    d       = div_r[NDS];
    r       = d.csr[DW-1:0];
    c       = d.crem[DW-1:0];
    er      = d.esr[DW-1:0];
    ec      = d.erem[DW-1:0];
    side_lo = (d.side == SIDE_BOTTOM) || (d.side == SIDE_TOP);
    ra      = r + DW'(d.side == SIDE_TOP);
    ma      = side_lo ? {1'b0, cols_r} : colsp1_r;
    nr      = (d.is_h && !d.es) ? er - DW'(1) : er;
    nc      = (!d.is_h && !d.es) ? ec - DW'(1) : ec;
    r1      = {1'b0, r} + DVW'(1);
    c1      = {1'b0, c} + DVW'(1);
    both    = d.cell_ok && d.edge_ok;

    mul_nxt.cell_ok = d.cell_ok;
    mul_nxt.edge_ok = d.edge_ok;
    mul_nxt.pa      = PW'(ra) * PW'(ma);
    mul_nxt.ca      = {1'b0, c} + DVW'(d.side == SIDE_RIGHT);
    mul_nxt.hadd    = side_lo ? '0 : hcount_r;
    mul_nxt.pb      = PW'(nr) * PW'(cols_r);
    mul_nxt.nc      = nc;
    if (d.is_h) begin
      mul_nxt.have_n = d.es ? (er < rows_r) : (er != '0);
      border         = (er == '0) || (er == rows_r);
    end else begin
      mul_nxt.have_n = d.es ? (ec < cols_r) : (ec != '0);
      border         = (ec == '0) || (ec == cols_r);
    end

    mul_nxt.pos = POS_NONE;
    if (both) begin
      if (d.is_h) begin
        if (er == r && ec == c)                  mul_nxt.pos = POS_BOTTOM;
        else if ({1'b0, er} == r1 && ec == c)    mul_nxt.pos = POS_TOP;
      end else begin
        if (er == r && ec == c)                  mul_nxt.pos = POS_LEFT;
        else if (er == r && {1'b0, ec} == c1)    mul_nxt.pos = POS_RIGHT;
      end
    end

    mul_nxt.horiz = d.edge_ok && d.is_h;
    mul_nxt.fixed = d.edge_ok && d.is_h && (er == rows_r);
    mul_nxt.inner = d.edge_ok && !border;
    mul_nxt.flux  = d.edge_ok && border && !(d.is_h && (er == rows_r));
  end

  always_comb begin
    logic [31:0] se, nb;
    logic        hit;
    se  = 32'(mul_r.pa) + 32'(mul_r.ca) + 32'(mul_r.hadd);
    nb  = 32'(mul_r.pb) + 32'(mul_r.nc);
    hit = mul_r.edge_ok && mul_r.have_n;
    out_nxt.side_edge            = mul_r.cell_ok ? se[EDGE_W-1:0] : '0;
    out_nxt.neighbor_cell        = hit ? nb[CELL_W-1:0] : '0;
    out_nxt.neighbor_missing     = !hit;
    out_nxt.edge_position        = mul_r.pos;
    out_nxt.edge_horizontal      = mul_r.horiz;
    out_nxt.edge_inner           = mul_r.inner;
    out_nxt.fixed_value_boundary = mul_r.fixed;
    out_nxt.flux_boundary        = mul_r.flux;
    out_nxt.index_out_of_range   = !(mul_r.cell_ok && mul_r.edge_ok);
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) in_r <= in_data;
    if (rdy[1]) div_r[0] <= prep_nxt;
    for (int k = 1; k <= NDS; k++) begin
      if (rdy[k+1]) div_r[k] <= step_nxt[k];
    end
    if (rdy[ST_MUL]) mul_r <= mul_nxt;
    if (rdy[ST_OUT]) out_r <= out_nxt;
  end

  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

  `GMEI_ASSERT_NXT(a_cfg_blocks_input, cfg_we, in_stall, "item taken right after config write")
  `GMEI_ASSERT_IMP(a_oor_no_position, out_valid && out_data.index_out_of_range, out_data.edge_position == POS_NONE, "position given for out-of-range index")
  `GMEI_ASSERT_IMP(a_missing_zero, out_valid && out_data.neighbor_missing, out_data.neighbor_cell == '0, "missing neighbor with nonzero cell")
  `GMEI_ASSERT_IMP(a_class_excl, out_valid, $onehot0({out_data.edge_inner, out_data.fixed_value_boundary, out_data.flux_boundary}), "edge classes overlap")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the mesh edge/cell indexer.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gmei_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_addr = REG_ROWS;
  logic [CFG_W-1:0] cfg_wdata = '0;

  grid_mesh_edge_cell_indexer_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  localparam int MAX_DIM = 1 << DIM_BITS_DEF;

  int unsigned rows_q = 1;
  int unsigned cols_q = 1;
  out_t expected_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int unsigned sat_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic int unsigned cell_edge(input int unsigned cell_no,
                                            input int unsigned side);
    int unsigned r, c, hc;
    r = cell_no / cols_q;
    c = cell_no % cols_q;
    hc = (rows_q + 1) * cols_q;
    if (side == SIDE_TOP) r++;
    if (side == SIDE_RIGHT) c++;
    if (side == SIDE_BOTTOM || side == SIDE_TOP) return r * cols_q + c;
    return hc + r * (cols_q + 1) + c;
  endfunction

  function automatic out_t index_mesh(input in_t q);
    out_t o;
    int unsigned ncell, hc, nedge, r, c, v, e, cell_no;
    bit cok, eok, border;
    o = '0;
    o.neighbor_missing = 1'b1;
    o.edge_position = POS_NONE;
    cell_no = 32'(q.cell_index);
    e = 32'(q.edge_index);
    ncell = rows_q * cols_q;
    hc = (rows_q + 1) * cols_q;
    nedge = hc + rows_q * (cols_q + 1);
    cok = cell_no < ncell;
    eok = e < nedge;
    if (cok) o.side_edge = EDGE_W'(cell_edge(cell_no, 32'(q.cell_side)));
    if (eok) begin
      if (e < hc) begin
        o.edge_horizontal = 1'b1;
        r = e / cols_q;
        c = e % cols_q;
        border = (r == 0) || (r == rows_q);
        o.fixed_value_boundary = (r == rows_q);
        if (!q.edge_side) begin
          if (r > 0) begin
            o.neighbor_cell = CELL_W'((r - 1) * cols_q + c);
            o.neighbor_missing = 1'b0;
          end
        end else if (r < rows_q) begin
          o.neighbor_cell = CELL_W'(r * cols_q + c);
          o.neighbor_missing = 1'b0;
        end
      end else begin
        v = e - hc;
        r = v / (cols_q + 1);
        c = v % (cols_q + 1);
        border = (c == 0) || (c == cols_q);
        if (!q.edge_side) begin
          if (c > 0) begin
            o.neighbor_cell = CELL_W'(r * cols_q + c - 1);
            o.neighbor_missing = 1'b0;
          end
        end else if (c < cols_q) begin
          o.neighbor_cell = CELL_W'(r * cols_q + c);
          o.neighbor_missing = 1'b0;
        end
      end
      o.edge_inner = !border;
      o.flux_boundary = border && !o.fixed_value_boundary;
      if (cok) begin
        for (int s = 3; s >= 0; s--)
          if (cell_edge(cell_no, s) == e) o.edge_position = 3'(s);
      end
    end
    o.index_out_of_range = !(cok && eok);
    return o;
  endfunction

  // valid stays up after a transfer; the next item or an idle cycle replaces it
  task automatic send_query(input in_t q);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    expected_q.push_back(index_mesh(q));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver stall, redrawn each cycle
  always @(posedge clk) begin
    out_stall <= hold_recv || (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) report("unexpected result", out_data, 0);
      else begin
        want = expected_q.pop_front();
        if (out_data.side_edge != want.side_edge)
          report("side_edge", out_data.side_edge, want.side_edge);
        if (out_data.neighbor_cell != want.neighbor_cell)
          report("neighbor_cell", out_data.neighbor_cell, want.neighbor_cell);
        if (out_data.neighbor_missing != want.neighbor_missing)
          report("neighbor_missing", out_data.neighbor_missing, want.neighbor_missing);
        if (out_data.edge_position != want.edge_position)
          report("edge_position", out_data.edge_position, want.edge_position);
        if (out_data.edge_horizontal != want.edge_horizontal)
          report("edge_horizontal", out_data.edge_horizontal, want.edge_horizontal);
        if (out_data.edge_inner != want.edge_inner)
          report("edge_inner", out_data.edge_inner, want.edge_inner);
        if (out_data.fixed_value_boundary != want.fixed_value_boundary)
          report("fixed_value_boundary", out_data.fixed_value_boundary,
                 want.fixed_value_boundary);
        if (out_data.flux_boundary != want.flux_boundary)
          report("flux_boundary", out_data.flux_boundary, want.flux_boundary);
        if (out_data.index_out_of_range != want.index_out_of_range)
          report("index_out_of_range", out_data.index_out_of_range,
                 want.index_out_of_range);
      end
    end
  end

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_dims(input logic [CFG_W-1:0] rv, input logic [CFG_W-1:0] cv);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= REG_ROWS;
    cfg_wdata <= rv;
    @(posedge clk);
    cfg_addr <= REG_COLS;
    cfg_wdata <= cv;
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_q = sat_dim(rv);
    cols_q = sat_dim(cv);
  endtask

  function automatic in_t mk(input int unsigned cell_no, input int unsigned cs,
                             input int unsigned e, input bit es);
    in_t q;
    q.cell_index = CELL_W'(cell_no);
    q.cell_side = 2'(cs);
    q.edge_index = EDGE_W'(e);
    q.edge_side = es;
    return q;
  endfunction

  // mostly in-range indices, sometimes near the limits, sometimes any bits
  function automatic in_t rand_query;
    int unsigned nc, ne, cell_no, e;
    nc = rows_q * cols_q;
    ne = (rows_q + 1) * cols_q + rows_q * (cols_q + 1);
    case ($urandom_range(9))
      0: cell_no = $urandom_range((1 << CELL_W) - 1);
      1: cell_no = nc - 1 + $urandom_range(1);
      default: cell_no = $urandom_range(nc - 1);
    endcase
    case ($urandom_range(9))
      0: e = $urandom_range((1 << EDGE_W) - 1);
      1: e = ne - 1 + $urandom_range(1);
      2: e = cell_edge(cell_no % nc, $urandom_range(3));
      default: e = $urandom_range(ne - 1);
    endcase
    if (cell_no >= (1 << CELL_W)) cell_no = (1 << CELL_W) - 1;
    if (e >= (1 << EDGE_W)) e = (1 << EDGE_W) - 1;
    return mk(cell_no, $urandom_range(3), e, 1'($urandom_range(1)));
  endfunction

  task automatic test_reset_mesh;
    for (int i = 0; i < 8; i++) send_query(mk(i % 2, i % 4, i, i[2]));
  endtask

  task automatic test_directed;
    write_dims(CFG_W'(3), CFG_W'(4));
    for (int s = 0; s < 4; s++) send_query(mk(5, s, cell_edge(5, s), s[0]));
    send_query(mk(0, SIDE_BOTTOM, 0, 1'b0));
    send_query(mk(11, SIDE_TOP, 15, 1'b1));
    send_query(mk(12, SIDE_LEFT, 16, 1'b0));
    send_query(mk(0, SIDE_RIGHT, 31, 1'b1));
    send_query(mk(0, SIDE_LEFT, 32, 1'b1));
    send_query(mk(0, SIDE_RIGHT, 20, 1'b0));
    send_query(mk((1 << CELL_W) - 1, SIDE_RIGHT, (1 << EDGE_W) - 1, 1'b1));
    write_dims(CFG_W'(0), 11'h7FF);
    send_query(mk(1023, SIDE_RIGHT, 2047, 1'b1));
    send_query(mk(0, SIDE_TOP, 1024, 1'b0));
    write_dims(CFG_W'(MAX_DIM), CFG_W'(MAX_DIM));
    send_query(mk(1048575, SIDE_TOP, 2099199, 1'b1));
    send_query(mk(1048575, SIDE_RIGHT, 2099200, 1'b0));
    send_query(mk(0, SIDE_BOTTOM, 1049600, 1'b0));
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) send_query(rand_query());
  endtask

  task automatic test_random;
    int dims[8][2] = '{'{1, 1}, '{1, 7}, '{9, 1}, '{5, 6},
                      '{MAX_DIM, 3}, '{2, MAX_DIM}, '{1500, 0}, '{37, 29}};
    for (int k = 0; k < 8; k++) begin
      write_dims(CFG_W'(dims[k][0]), CFG_W'(dims[k][1]));
      send_idle_pct = 30; recv_idle_pct = 72;
      run_random(60);
      send_idle_pct = 72; recv_idle_pct = 30;
      run_random(60);
      send_idle_pct = 0; recv_idle_pct = 0;
      run_random(60);
    end
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_recv = 1'b1;
        repeat (60) @(posedge clk);
        hold_recv = 1'b0;
      end
      run_random(40);
    join
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_mesh();
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end
endmodule
